/* sv/rgba_source_over_blend_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the source-over blender
// Shared property shapes, clocked on clk and held off while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef RGBA_SOURCE_OVER_BLEND_MACROS_SVH
`define RGBA_SOURCE_OVER_BLEND_MACROS_SVH

// Check that cons holds in every cycle in which ante holds.
`define RGBBLEND_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Check that cond never holds.
`define RGBBLEND_ASSERT_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error(msg);

`endif

/* sv/rgbblend_pkg.sv */
// ----------------------------------------------------------------------------
// Source-over blender package
// Widths, pipeline depths and the beat types passed between the stages.
// ----------------------------------------------------------------------------
package rgbblend_pkg;

  localparam int CH      = 3;   // colour channels: 0 red, 1 green, 2 blue
  localparam int PIX_W   = 8;
  localparam int PROD_W  = 24;  // colour times weight
  localparam int NUM_W   = 25;  // sum of the two weighted terms
  localparam int DEN_W   = 16;  // output alpha times 255
  localparam int QUO_W   = 9;   // quotient with one overflow bit

  localparam int FRONT_STAGES = 4;
  localparam int DIV_STAGES   = QUO_W;
  localparam int LATENCY      = FRONT_STAGES + DIV_STAGES + 1;

  localparam logic [PIX_W-1:0] PIX_MAX    = 8'd255;
  localparam logic [PIX_W-1:0] ROUND_HALF = 8'd127;

  typedef logic [CH-1:0][PIX_W-1:0] colour_t;

  typedef struct packed {
    colour_t          dst;
    logic [PIX_W-1:0] dst_a;
    colour_t          src;
    logic [PIX_W-1:0] src_a;
  } pix_in_t;

  // Bypass data carried alongside the divider.
  typedef struct packed {
    logic             pass;    // transparent source: destination goes through
    colour_t          colour;  // destination colour
    logic [PIX_W-1:0] alpha;   // final output alpha
  } side_t;

  typedef struct packed {
    logic [CH-1:0][NUM_W-1:0] num;
    logic [DEN_W-1:0]         den;
    side_t                    side;
  } front_t;

  typedef struct packed {
    logic [CH-1:0][QUO_W-1:0] quo;
    side_t                    side;
  } div_out_t;

endpackage

/* sv/rgba_source_over_blend.sv */
// ----------------------------------------------------------------------------
// Source-over alpha blender, RGBA8888
// Blends a non-premultiplied source colour over one destination pixel.
// ----------------------------------------------------------------------------
//
//   channel  handshake          payload
//   -------  -----------------  ------------------------------------------
//   input    start / busy       in_dst_red..in_dst_alpha, in_src_red..alpha
//   result   out_valid (strobe) out_red, out_green, out_blue, out_alpha_value
//
// One beat enters per clock; busy is always low. A result strobes one cycle
// wide, in input order, once its beat has passed the pipe. The depth is set
// by the nine one-bit stages of the divider plus four front stages and the
// output register.
// Synchronous reset clears every valid bit; beats in flight are dropped.
// The receiver cannot stall, so nothing in the pipe ever waits.
//
// Datapath: num = s*a*255 + d*da*(255-a), den = oa*255 with
// oa = a + round(da*(255-a)/255). The quotient is one colour channel; a
// quotient of 256 or more saturates at 255. An opaque source or opaque
// destination reduces exactly to the same division, so only a transparent
// source takes the bypass, which hands the destination pixel through.
// ----------------------------------------------------------------------------
module rgba_source_over_blend (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic [rgbblend_pkg::PIX_W-1:0] in_dst_red,
  input  logic [rgbblend_pkg::PIX_W-1:0] in_dst_green,
  input  logic [rgbblend_pkg::PIX_W-1:0] in_dst_blue,
  input  logic [rgbblend_pkg::PIX_W-1:0] in_dst_alpha,
  input  logic [rgbblend_pkg::PIX_W-1:0] in_src_red,
  input  logic [rgbblend_pkg::PIX_W-1:0] in_src_green,
  input  logic [rgbblend_pkg::PIX_W-1:0] in_src_blue,
  input  logic [rgbblend_pkg::PIX_W-1:0] in_src_alpha,
  output logic                          out_valid,
  output logic [rgbblend_pkg::PIX_W-1:0] out_red,
  output logic [rgbblend_pkg::PIX_W-1:0] out_green,
  output logic [rgbblend_pkg::PIX_W-1:0] out_blue,
  output logic [rgbblend_pkg::PIX_W-1:0] out_alpha_value
);
  import rgbblend_pkg::*;

  pix_in_t  in_pix;
  logic     accept;
  logic     front_v, div_v;
  front_t   front_beat;
  div_out_t div_beat;

  logic             valid_r;
  colour_t          colour_r, colour_nxt;
  logic [PIX_W-1:0] alpha_r;

  // Never hold the source off: the pipe advances every cycle.
  assign busy   = 1'b0;
  assign accept = start && !busy;

  assign in_pix.dst   = {in_dst_blue, in_dst_green, in_dst_red};
  assign in_pix.dst_a = in_dst_alpha;
  assign in_pix.src   = {in_src_blue, in_src_green, in_src_red};
  assign in_pix.src_a = in_src_alpha;

  rgbblend_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (accept),
    .in_pix    (in_pix),
    .out_valid (front_v),
    .out_beat  (front_beat)
  );

  rgbblend_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (front_v),
    .in_beat   (front_beat),
    .out_valid (div_v),
    .out_beat  (div_beat)
  );

  // Saturate an overflowing quotient, or take the destination on bypass.
  always_comb begin
    for (int i = 0; i < CH; i++) begin
      if (div_beat.side.pass) begin
        colour_nxt[i] = div_beat.side.colour[i];
      end else if (div_beat.quo[i][QUO_W-1]) begin
        colour_nxt[i] = PIX_MAX;
      end else begin
        colour_nxt[i] = div_beat.quo[i][PIX_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= div_v;
    end
  end

  always_ff @(posedge clk) begin
    colour_r <= colour_nxt;
    alpha_r  <= div_beat.side.alpha;
  end

  assign out_valid       = valid_r;
  assign out_red         = colour_r[0];
  assign out_green       = colour_r[1];
  assign out_blue        = colour_r[2];
  assign out_alpha_value = alpha_r;

endmodule

/* sv/rgbblend_front.sv */
// ----------------------------------------------------------------------------
// Blender front end
// Four register stages: capture, weights, products and output alpha,
// numerator/divisor.
// ----------------------------------------------------------------------------
module rgbblend_front (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  input  rgbblend_pkg::pix_in_t in_pix,
  output logic                  out_valid,
  output rgbblend_pkg::front_t  out_beat
);
  import rgbblend_pkg::*;

  // stage 1: captured beat
  logic    v1_r;
  pix_in_t p1_r;

  // stage 2: weights
  logic             v2_r;
  logic [DEN_W-1:0] sf2_r, df2_r;
  logic [DEN_W-1:0] sf2_nxt, df2_nxt;
  logic [PIX_W-1:0] inv2;
  colour_t          src2_r, dst2_r;
  logic [PIX_W-1:0] a2_r, da2_r;
  logic             pass2_r;

  // stage 3: products and output alpha
  logic                      v3_r;
  logic [CH-1:0][PROD_W-1:0] ps3_r, pd3_r, ps3_nxt, pd3_nxt;
  logic [DEN_W-1:0]          rnd3, div3;
  logic [PIX_W-1:0]          oa3_r, oa3_nxt;
  colour_t                   dst3_r;
  logic [PIX_W-1:0]          da3_r;
  logic                      pass3_r;

  // stage 4: numerator and divisor
  logic   v4_r;
  front_t f4_r, f4_nxt;

  always_comb begin
    inv2    = PIX_MAX - p1_r.src_a;
    sf2_nxt = {p1_r.src_a, 8'h00} - {8'h00, p1_r.src_a};
    df2_nxt = {8'h00, p1_r.dst_a} * {8'h00, inv2};
  end

  always_comb begin
    for (int i = 0; i < CH; i++) begin
      ps3_nxt[i] = PROD_W'(src2_r[i]) * PROD_W'(sf2_r);
      pd3_nxt[i] = PROD_W'(dst2_r[i]) * PROD_W'(df2_r);
    end
    // rounded divide by 255, exact for the product of two 8-bit values
    rnd3    = df2_r + DEN_W'(ROUND_HALF);
    div3    = rnd3 + (rnd3 >> 8) + 16'd1;
    oa3_nxt = a2_r + div3[15:8];
  end

  always_comb begin
    for (int i = 0; i < CH; i++) begin
      f4_nxt.num[i] = NUM_W'(ps3_r[i]) + NUM_W'(pd3_r[i]);
    end
    f4_nxt.den         = {oa3_r, 8'h00} - {8'h00, oa3_r};
    f4_nxt.side.pass   = pass3_r;
    f4_nxt.side.colour = dst3_r;
    f4_nxt.side.alpha  = pass3_r ? da3_r : oa3_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      v1_r <= in_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    p1_r    <= in_pix;
    sf2_r   <= sf2_nxt;
    df2_r   <= df2_nxt;
    src2_r  <= p1_r.src;
    dst2_r  <= p1_r.dst;
    a2_r    <= p1_r.src_a;
    da2_r   <= p1_r.dst_a;
    pass2_r <= (p1_r.src_a == '0);
    ps3_r   <= ps3_nxt;
    pd3_r   <= pd3_nxt;
    oa3_r   <= oa3_nxt;
    dst3_r  <= dst2_r;
    da3_r   <= da2_r;
    pass3_r <= pass2_r;
    f4_r    <= f4_nxt;
  end

  assign out_valid = v4_r;
  assign out_beat  = f4_r;

endmodule

/* sv/rgbblend_div.sv */
// ----------------------------------------------------------------------------
// Blender divider
// Restoring division, one quotient bit per stage, three lanes on one divisor.
// ----------------------------------------------------------------------------
module rgbblend_div (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  input  rgbblend_pkg::front_t    in_beat,
  output logic                    out_valid,
  output rgbblend_pkg::div_out_t  out_beat
);
  import rgbblend_pkg::*;

  typedef struct packed {
    logic [CH-1:0][NUM_W-1:0] rem;
    logic [CH-1:0][QUO_W-1:0] quo;
    logic [DEN_W-1:0]         den;
    side_t                    side;
  } dstage_t;

  dstage_t               stage_r [DIV_STAGES];
  logic [DIV_STAGES-1:0] vld_r;
  dstage_t               head;

  always_comb begin
    head.rem  = in_beat.num;
    head.quo  = '0;
    head.den  = in_beat.den;
    head.side = in_beat.side;
  end

  for (genvar g = 0; g < DIV_STAGES; g++) begin : g_stage
    localparam int Bit = QUO_W - 1 - g;

    dstage_t              cur, step_nxt;
    logic                 cur_v;
    logic [NUM_W-1:0]     trial;

    if (g == 0) begin : g_head
      assign cur   = head;
      assign cur_v = in_valid;
    end else begin : g_chain
      assign cur   = stage_r[g-1];
      assign cur_v = vld_r[g-1];
    end

    always_comb begin
      trial    = NUM_W'(cur.den) << Bit;
      step_nxt = cur;
      for (int l = 0; l < CH; l++) begin
        if (cur.rem[l] >= trial) begin
          step_nxt.rem[l]      = cur.rem[l] - trial;
          step_nxt.quo[l][Bit] = 1'b1;
        end
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[g] <= 1'b0;
      end else begin
        vld_r[g] <= cur_v;
      end
    end

    always_ff @(posedge clk) begin
      stage_r[g] <= step_nxt;
    end
  end

  assign out_valid     = vld_r[DIV_STAGES-1];
  assign out_beat.quo  = stage_r[DIV_STAGES-1].quo;
  assign out_beat.side = stage_r[DIV_STAGES-1].side;

endmodule

/* sv/rgbblend_checker.sv */
// ----------------------------------------------------------------------------
// Source-over blender port checker
// Relates each result beat to the input beat that it was computed from.
// ----------------------------------------------------------------------------
`include "rgba_source_over_blend_macros.svh"

module rgbblend_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          start,
  input logic                          busy,
  input logic [rgbblend_pkg::PIX_W-1:0] in_dst_red,
  input logic [rgbblend_pkg::PIX_W-1:0] in_dst_green,
  input logic [rgbblend_pkg::PIX_W-1:0] in_dst_blue,
  input logic [rgbblend_pkg::PIX_W-1:0] in_dst_alpha,
  input logic [rgbblend_pkg::PIX_W-1:0] in_src_red,
  input logic [rgbblend_pkg::PIX_W-1:0] in_src_green,
  input logic [rgbblend_pkg::PIX_W-1:0] in_src_blue,
  input logic [rgbblend_pkg::PIX_W-1:0] in_src_alpha,
  input logic                          out_valid,
  input logic [rgbblend_pkg::PIX_W-1:0] out_red,
  input logic [rgbblend_pkg::PIX_W-1:0] out_green,
  input logic [rgbblend_pkg::PIX_W-1:0] out_blue,
  input logic [rgbblend_pkg::PIX_W-1:0] out_alpha_value
);
  import rgbblend_pkg::*;

  logic took;
  assign took = start && !busy;

  `RGBBLEND_ASSERT_IMPL(a_no_phantom, out_valid, $past(took, LATENCY), "result beat without an input beat")

  `RGBBLEND_ASSERT_IMPL(a_transparent_pass, out_valid && ($past(in_src_alpha, LATENCY) == '0), (out_red == $past(in_dst_red, LATENCY)) && (out_green == $past(in_dst_green, LATENCY)) && (out_blue == $past(in_dst_blue, LATENCY)) && (out_alpha_value == $past(in_dst_alpha, LATENCY)), "transparent source must pass the destination")

  `RGBBLEND_ASSERT_IMPL(a_opaque_copy, out_valid && ($past(in_src_alpha, LATENCY) == PIX_MAX), (out_red == $past(in_src_red, LATENCY)) && (out_green == $past(in_src_green, LATENCY)) && (out_blue == $past(in_src_blue, LATENCY)) && (out_alpha_value == PIX_MAX), "opaque source must copy the source colour")

  `RGBBLEND_ASSERT_NEVER(a_alpha_floor, out_valid && (out_alpha_value < $past(in_src_alpha, LATENCY)), "output alpha below source alpha")

endmodule

bind rgba_source_over_blend rgbblend_checker u_rgbblend_checker (.*);
